// ===== rtl/lpcp_pkg.sv =====
// Shared types, constants and helper functions for the lidar point to camera
// projection block. Depends on nothing; every other RTL file imports it.
`default_nettype none

package lpcp_pkg;

  localparam int unsigned DefImgWidth  = 1242;
  localparam int unsigned DefImgHeight = 375;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_W     = 48;
  localparam int unsigned REG_IDX_W = 3;

  // Accumulator width covers three 32-bit products plus a shifted offset.
  localparam int unsigned ACC_W   = 36;
  // Quotient bits: enough to reach 4096, one bit more to flag overflow.
  localparam int unsigned QUOT_W  = 13;
  localparam int unsigned REM_W   = ACC_W + QUOT_W - 1;
  localparam int unsigned EPOCH_W = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Multiplier sequence: rows 0..2 camera, row 3 range, rows 4..6 u, v, w.
  localparam int unsigned MUL_ROWS  = 7;
  localparam int unsigned RANGE_ROW = 3;
  localparam int unsigned CAM_ROWS  = 3;

  // 10000 square meters in Q16.16.
  localparam logic [31:0] RANGE_LIMIT_SQ = 32'd655360000;

  typedef enum logic [2:0] {
    REG_ROT_ROW_X   = 3'd0,
    REG_ROT_ROW_Y   = 3'd1,
    REG_ROT_ROW_Z   = 3'd2,
    REG_SHIFT_XYZ   = 3'd3,
    REG_PROJ_ROW_U  = 3'd4,
    REG_PROJ_ROW_V  = 3'd5,
    REG_PROJ_ROW_W  = 3'd6,
    REG_PROJ_OFFSET = 3'd7
  } reg_idx_e;

  typedef enum logic {
    FUNC_FRAME_START = 1'b0,
    FUNC_POINT       = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_PLACED        = 3'd0,
    ST_BEHIND        = 3'd1,
    ST_TOO_FAR       = 3'd2,
    ST_OFF_IMAGE     = 3'd3,
    ST_COL_FULL      = 3'd4,
    ST_FRAME_CLEARED = 3'd5
  } status_e;

  typedef struct packed {
    logic               func;
    logic signed [15:0] pt_x;
    logic signed [15:0] pt_y;
    logic signed [15:0] pt_z;
    logic [7:0]         pt_intensity;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [15:0] cam_z;
    logic [7:0]         out_intensity;
    logic [11:0]        pix_u;
    logic [11:0]        pix_v;
    status_e            status;
  } out_item_t;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [15:0] cam_z;
    logic [7:0]         intensity;
    logic [11:0]        u;
    logic [11:0]        v;
    status_e            status;
  } task_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DRAIN,
    F_CHECK,
    F_DIV_U,
    F_DIV_V,
    F_FINISH,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ADDR,
    B_READ,
    B_CHECK,
    B_OUT
  } back_state_e;

  function automatic logic signed [15:0] lane(input logic [REG_W-1:0] r,
                                              input logic [1:0] k);
    logic signed [15:0] res;
    case (k)
      2'd0:    res = r[15:0];
      2'd1:    res = r[31:16];
      default: res = r[47:32];
    endcase
    return res;
  endfunction

  // Floor shift by 14 (Q.22 to Q8.8), then saturate to 16 bits signed.
  function automatic logic signed [15:0] cam_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-15:0] s;
    logic signed [15:0]       res;
    s = a[ACC_W-1:14];
    if (s > 22'sd32767) begin
      res = 16'sh7FFF;
    end else if (s < -22'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = s[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lpcp_queue.sv =====
// Short in-order queue of classified items between the front and back parts.
// Depends on lpcp_pkg for the entry type and depth.
`default_nettype none

module lpcp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lpcp_pkg::task_t push_data_i,
  input  logic            pop_i,
  output lpcp_pkg::task_t head_o,
  output logic            full_o,
  output logic            empty_o
);
  import lpcp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  task_t            entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lpcp_front.sv =====
// Front part: configuration registers, input beat acceptance, camera transform,
// range check, projection and the shared one-bit-a-cycle divider. Uses lpcp_pkg.
`default_nettype none

module lpcp_front #(
  parameter int unsigned IMG_WIDTH  = lpcp_pkg::DefImgWidth,
  parameter int unsigned IMG_HEIGHT = lpcp_pkg::DefImgHeight
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpcp_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [lpcp_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lpcp_pkg::in_item_t             in_data_i,
  output logic                           push_o,
  output lpcp_pkg::task_t                push_data_o,
  input  logic                           full_i
);
  import lpcp_pkg::*;

  localparam logic [QUOT_W-1:0] U_HI     = QUOT_W'(IMG_WIDTH - 1);
  localparam logic [QUOT_W-1:0] V_HI     = QUOT_W'(IMG_HEIGHT - 1);
  localparam logic [2:0]        LAST_ROW = 3'(MUL_ROWS - 1);
  localparam logic [2:0]        RNG_ROW  = 3'(RANGE_ROW);
  localparam logic [1:0]        LAST_CAM = 2'(CAM_ROWS - 1);

  front_state_e state_q, state_d;

  logic [REG_W-1:0]        cfg_q [NUM_REGS];
  in_item_t                pt_q;
  logic [2:0]              row_q;
  logic [1:0]              col_q;
  logic                    mv_q;
  logic [2:0]              mrow_q;
  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q [MUL_ROWS];
  logic [REM_W-1:0]        rem_q;
  logic [REM_W-1:0]        dvs_q;
  logic [QUOT_W-1:0]       quot_q;
  logic [QUOT_W-1:0]       uq_q;
  logic [3:0]              cnt_q;
  task_t                   task_q;

  logic signed [15:0]      cam [CAM_ROWS];
  logic signed [15:0]      p_sel, c_sel, op_a, op_b;
  logic signed [ACC_W+2:0] u_ext, v_ext, w8;
  logic                    u_bad, v_bad, w_bad;
  logic                    reject;
  status_e                 early_status;
  logic                    ge;
  logic [REM_W-1:0]        rem_nxt;
  logic [QUOT_W-1:0]       quot_nxt;
  logic                    in_bounds;

  for (genvar r = 0; r < CAM_ROWS; r++) begin : g_cam
    assign cam[r] = cam_sat(acc_q[r]);
  end

  // Multiplier operands: rotation times point, point squared, then
  // projection coefficients times camera coordinates.
  always_comb begin
    case (col_q)
      2'd0:    begin p_sel = pt_q.pt_x; c_sel = cam[0]; end
      2'd1:    begin p_sel = pt_q.pt_y; c_sel = cam[1]; end
      default: begin p_sel = pt_q.pt_z; c_sel = cam[2]; end
    endcase
    op_a = (row_q == RNG_ROW) ? p_sel : lane(cfg_q[row_q], col_q);
    op_b = (row_q <= RNG_ROW) ? p_sel : c_sel;
  end

  // Classification of a finished point.
  always_comb begin
    u_ext  = (ACC_W+3)'(acc_q[4]);
    v_ext  = (ACC_W+3)'(acc_q[5]);
    w8     = $signed({acc_q[6], 3'b000});
    w_bad  = (acc_q[6] <= 0);
    // A positive quotient of at least 8192 can never land on the image.
    u_bad  = (acc_q[4] <= 0) || (u_ext >= w8);
    v_bad  = (acc_q[5] <= 0) || (v_ext >= w8);
    reject = 1'b1;
    if (cam[2] <= 16'sd0) begin
      early_status = ST_BEHIND;
    end else if (acc_q[RANGE_ROW][31:0] > RANGE_LIMIT_SQ) begin
      early_status = ST_TOO_FAR;
    end else if (w_bad || u_bad || v_bad) begin
      early_status = ST_OFF_IMAGE;
    end else begin
      early_status = ST_PLACED;
      reject       = 1'b0;
    end
  end

  // Restoring division step.
  always_comb begin
    ge       = (rem_q >= dvs_q);
    rem_nxt  = ge ? rem_q - dvs_q : rem_q;
    quot_nxt = {quot_q[QUOT_W-2:0], ge};
    in_bounds = (uq_q != '0) && (uq_q < U_HI) && (quot_q != '0) && (quot_q < V_HI);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.func == FUNC_POINT) ? F_MUL : F_PUSH;
        end
      end
      F_MUL: begin
        if (row_q == LAST_ROW && col_q == 2'd2) begin
          state_d = F_DRAIN;
        end
      end
      F_DRAIN:  state_d = F_CHECK;
      F_CHECK:  state_d = reject ? F_PUSH : F_DIV_U;
      F_DIV_U: begin
        if (cnt_q == '0) begin
          state_d = F_DIV_V;
        end
      end
      F_DIV_V: begin
        if (cnt_q == '0) begin
          state_d = F_FINISH;
        end
      end
      F_FINISH: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default:  state_d = F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o  = (state_q != F_IDLE);
    push_o      = (state_q == F_PUSH) && !full_i;
    push_data_o = task_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      mv_q    <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      mv_q    <= (state_q == F_MUL);
      if (cfg_we_i) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mrow_q <= row_q;
    prod_q <= op_a * op_b;
    if (mv_q) begin
      acc_q[mrow_q] <= acc_q[mrow_q] + ACC_W'(prod_q);
    end
    case (state_q)
      F_IDLE: begin
        pt_q  <= in_data_i;
        row_q <= '0;
        col_q <= '0;
        for (int r = 0; r < CAM_ROWS; r++) begin
          acc_q[r]     <= ACC_W'(lane(cfg_q[REG_SHIFT_XYZ], 2'(r))) <<< 12;
          acc_q[4 + r] <= ACC_W'(lane(cfg_q[REG_PROJ_OFFSET], 2'(r))) <<< 8;
        end
        acc_q[RANGE_ROW] <= '0;
        task_q           <= task_t'({($bits(task_t) - 3)'(0), ST_FRAME_CLEARED});
      end
      F_MUL: begin
        if (col_q == 2'd2) begin
          col_q <= '0;
          row_q <= row_q + 3'd1;
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
      F_CHECK: begin
        task_q.cam_x     <= cam[0];
        task_q.cam_y     <= cam[1];
        task_q.cam_z     <= cam[LAST_CAM];
        task_q.intensity <= pt_q.pt_intensity;
        task_q.u         <= '0;
        task_q.v         <= '0;
        task_q.status    <= early_status;
        rem_q  <= REM_W'({acc_q[4][ACC_W-3:0], 10'b0});
        dvs_q  <= {acc_q[6], 12'b0};
        quot_q <= '0;
        cnt_q  <= 4'(QUOT_W - 1);
      end
      F_DIV_U: begin
        if (cnt_q == '0) begin
          uq_q   <= quot_nxt;
          rem_q  <= REM_W'({acc_q[5][ACC_W-3:0], 10'b0});
          dvs_q  <= {acc_q[6], 12'b0};
          quot_q <= '0;
          cnt_q  <= 4'(QUOT_W - 1);
        end else begin
          rem_q  <= rem_nxt;
          dvs_q  <= dvs_q >> 1;
          quot_q <= quot_nxt;
          cnt_q  <= cnt_q - 4'd1;
        end
      end
      F_DIV_V: begin
        rem_q  <= rem_nxt;
        dvs_q  <= dvs_q >> 1;
        quot_q <= quot_nxt;
        cnt_q  <= cnt_q - 4'd1;
      end
      F_FINISH: begin
        if (in_bounds) begin
          task_q.u      <= uq_q[11:0];
          task_q.v      <= quot_q[11:0];
          task_q.status <= ST_PLACED;
        end else begin
          task_q.status <= ST_OFF_IMAGE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lpcp_back.sv =====
// Back part: pixel occupancy store with epoch tags, column search and the
// output register. Uses lpcp_pkg for the item types and states.
`default_nettype none

module lpcp_back #(
  parameter int unsigned IMG_WIDTH  = lpcp_pkg::DefImgWidth,
  parameter int unsigned IMG_HEIGHT = lpcp_pkg::DefImgHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpcp_pkg::task_t     head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpcp_pkg::out_item_t out_data_o
);
  import lpcp_pkg::*;

  localparam int unsigned DEPTH  = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0]  ROW_STEP  = ADDR_W'(IMG_WIDTH);
  localparam logic [11:0]        LAST_ROW  = 12'(IMG_HEIGHT - 2);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

  // An entry is taken when its tag equals the current epoch.
  logic [EPOCH_W-1:0] mem [DEPTH];

  back_state_e        state_q, state_d;
  logic [ADDR_W-1:0]  addr_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [EPOCH_W-1:0] rd_q;
  logic [11:0]        row_q;
  task_t              cur_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               out_free;
  logic               is_free;
  logic               mem_we;
  logic [EPOCH_W-1:0] mem_wdata;
  logic               load_out;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_free  = (rd_q != epoch_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (addr_q == LAST_ADDR) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          state_d = (head_i.status == ST_PLACED) ? B_ADDR : B_OUT;
        end
      end
      B_ADDR:  state_d = B_READ;
      B_READ:  state_d = B_CHECK;
      B_CHECK: begin
        if (is_free || row_q == LAST_ROW) begin
          state_d = B_OUT;
        end else begin
          state_d = B_READ;
        end
      end
      B_OUT: begin
        if (out_free) begin
          if (cur_q.status == ST_FRAME_CLEARED && epoch_q == EPOCH_MAX) begin
            state_d = B_CLEAR;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    pop_o     = (state_q == B_IDLE) && !empty_i;
    load_out  = (state_q == B_OUT) && out_free;
    mem_we    = (state_q == B_CLEAR) || ((state_q == B_CHECK) && is_free);
    mem_wdata = (state_q == B_CLEAR) ? '0 : epoch_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      addr_q      <= '0;
      epoch_q     <= EPOCH_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == LAST_ADDR) begin
            epoch_q <= EPOCH_ONE;
          end
        end
        B_ADDR: begin
          addr_q <= ADDR_W'(32'(cur_q.v) * 32'(IMG_WIDTH)) + ADDR_W'(cur_q.u);
        end
        B_CHECK: begin
          if (!is_free) begin
            addr_q <= addr_q + ROW_STEP;
          end
        end
        B_OUT: begin
          if (out_free && cur_q.status == ST_FRAME_CLEARED) begin
            if (epoch_q == EPOCH_MAX) begin
              addr_q <= '0;
            end else begin
              epoch_q <= epoch_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
      row_q <= head_i.v;
    end
    if (state_q == B_CHECK) begin
      if (is_free) begin
        cur_q.v <= row_q;
      end else if (row_q == LAST_ROW) begin
        cur_q.u      <= '0;
        cur_q.v      <= '0;
        cur_q.status <= ST_COL_FULL;
      end else begin
        row_q <= row_q + 12'd1;
      end
    end
    if (load_out) begin
      out_q.cam_x         <= cur_q.cam_x;
      out_q.cam_y         <= cur_q.cam_y;
      out_q.cam_z         <= cur_q.cam_z;
      out_q.out_intensity <= cur_q.intensity;
      out_q.pix_u         <= cur_q.u;
      out_q.pix_v         <= cur_q.v;
      out_q.status        <= cur_q.status;
    end
  end

  // Occupancy store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    rd_q <= mem[addr_q];
  end

endmodule

`default_nettype wire

// ===== rtl/lidar_point_camera_projection.sv =====
// Top level of the lidar point to camera projection block: front part, queue,
// back part and a few checks. Depends on lpcp_pkg, lpcp_front, lpcp_queue, lpcp_back.
//
// Usage. Input beats (in_valid_i / in_stall_o) carry either a frame start
// (func 0) or a lidar point (func 1). Every input beat gives exactly one output
// beat (out_valid_o / out_stall_i), in order. Eight 48-bit registers are written
// through cfg_we_i / cfg_index_i / cfg_data_i; the user must write them only while
// the block is idle, which the block does not enforce. The front takes one point
// at a time: 21 products on a single 16x16 multiplier plus drain and classification,
// and for a point that reaches the image two 13-step divisions sharing one
// restoring divider. The back passes an unplaced item straight to the output
// register; for a placed one it forms the address, then reads and checks the
// occupancy store once per row searched down the column before loading the result.
// The queue between the two lets the front work on the next point while the back
// searches or waits on a stalled receiver.
// Reset. Configuration registers and queue counts read zero. The occupancy store
// then runs a clearing pass over IMG_WIDTH*IMG_HEIGHT entries (465750 by default);
// items queue up behind it. A frame start normally clears the store at no extra cost
// by bumping a 4-bit epoch; every fifteenth one repeats the clearing pass.
// Stall. A stalled result holds in the output register; the back then stops,
// the queue fills and the front finally holds in_stall_o high.
`default_nettype none

module lidar_point_camera_projection #(
  parameter int unsigned IMG_WIDTH  = lpcp_pkg::DefImgWidth,
  parameter int unsigned IMG_HEIGHT = lpcp_pkg::DefImgHeight
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpcp_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [lpcp_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lpcp_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lpcp_pkg::out_item_t            out_data_o
);
  import lpcp_pkg::*;

  task_t push_data, head;
  logic  push, pop, full, empty;

  lpcp_front #(
    .IMG_WIDTH (IMG_WIDTH),
    .IMG_HEIGHT(IMG_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  lpcp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (full),
    .empty_o    (empty)
  );

  lpcp_back #(
    .IMG_WIDTH (IMG_WIDTH),
    .IMG_HEIGHT(IMG_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // The front works on one item at a time, so it stalls right after a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front took a second beat while busy");

  // A placed pixel lies strictly inside the image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_PLACED |->
      out_data_o.pix_u != '0 && out_data_o.pix_v != '0 &&
      out_data_o.pix_u < 12'(IMG_WIDTH - 1) && out_data_o.pix_v < 12'(IMG_HEIGHT - 1))
    else $error("placed pixel outside the image");

  // Anything that is not placed carries no pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_PLACED |->
      out_data_o.pix_u == '0 && out_data_o.pix_v == '0)
    else $error("pixel reported for an unplaced result");

  // Queue is never pushed while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("push into a full queue");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for lidar_point_camera_projection: directed beats,
// then random point streams under several calibrations and idling patterns.
// Depends only on lpcp_pkg and the block itself.
`timescale 1ns / 100ps

module tb;
  import lpcp_pkg::*;

  localparam int unsigned ImgW = DefImgWidth;
  localparam int unsigned ImgH = DefImgHeight;
  // Reset clearing pass, repeated clearing passes and worst column searches all fit.
  localparam longint CycleLimit = 20_000_000;
  localparam int TailCycles = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  lidar_point_camera_projection dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Our own copy of the calibration registers and of the pixel occupancy map.
  logic [REG_W-1:0] calib[NUM_REGS];
  bit pixel_used[ImgW*ImgH];
  out_item_t pending_results[$];

  int errors = 0;
  int points_sent = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int placed_seen = 0;
  int full_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  function automatic longint coef(logic [REG_W-1:0] r, int k);
    logic signed [15:0] t;
    t = r[16*k +: 16];
    return t;
  endfunction

  function automatic logic [REG_W-1:0] pack3(int a, int b, int c);
    logic [15:0] la, lb, lc;
    la = a[15:0];
    lb = b[15:0];
    lc = c[15:0];
    return {lc, lb, la};
  endfunction

  // Expected result of one beat; also updates the occupancy map.
  function automatic out_item_t project_point(in_item_t it);
    out_item_t r;
    longint p[3], cam[3];
    longint s, uu, vv, ww, u, v, row;
    bit found;
    r = '0;
    if (it.func == FUNC_FRAME_START) begin
      foreach (pixel_used[i]) pixel_used[i] = 1'b0;
      r.status = ST_FRAME_CLEARED;
      return r;
    end
    p[0] = it.pt_x;
    p[1] = it.pt_y;
    p[2] = it.pt_z;
    for (int rr = 0; rr < 3; rr++) begin
      s = coef(calib[REG_SHIFT_XYZ], rr) * 4096;
      for (int k = 0; k < 3; k++) s += coef(calib[rr], k) * p[k];
      s = s >>> 14;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      cam[rr] = s;
    end
    r.cam_x = cam[0][15:0];
    r.cam_y = cam[1][15:0];
    r.cam_z = cam[2][15:0];
    r.out_intensity = it.pt_intensity;
    if (cam[2] <= 0) begin
      r.status = ST_BEHIND;
    end else if (p[0]*p[0] + p[1]*p[1] + p[2]*p[2] > 64'd10000 * 65536) begin
      r.status = ST_TOO_FAR;
    end else begin
      uu = coef(calib[REG_PROJ_OFFSET], 0) * 256;
      vv = coef(calib[REG_PROJ_OFFSET], 1) * 256;
      ww = coef(calib[REG_PROJ_OFFSET], 2) * 256;
      for (int k = 0; k < 3; k++) begin
        uu += coef(calib[REG_PROJ_ROW_U], k) * cam[k];
        vv += coef(calib[REG_PROJ_ROW_V], k) * cam[k];
        ww += coef(calib[REG_PROJ_ROW_W], k) * cam[k];
      end
      if (ww <= 0) begin
        r.status = ST_OFF_IMAGE;
      end else begin
        // Division truncates toward zero, as longint division does.
        u = (uu * 1024) / ww;
        v = (vv * 1024) / ww;
        if (!(u > 0 && v > 0 && u < ImgW - 1 && v < ImgH - 1)) begin
          r.status = ST_OFF_IMAGE;
        end else begin
          // Walk down the column to the first free pixel.
          found = 1'b0;
          for (row = v; row < ImgH - 1; row++) begin
            if (!pixel_used[row*ImgW + u]) begin
              pixel_used[row*ImgW + u] = 1'b1;
              found = 1'b1;
              break;
            end
          end
          if (found) begin
            r.status = ST_PLACED;
            r.pix_u = u[11:0];
            r.pix_v = row[11:0];
          end else begin
            r.status = ST_COL_FULL;
          end
        end
      end
    end
    return r;
  endfunction

  // Input side: predict at every accepted beat, so the queue stays in beat order.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      pending_results = {pending_results, project_point(in_data)};
    end
  end

  // Output side: compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status == ST_PLACED) placed_seen++;
        if (exp_r.status == ST_COL_FULL) full_seen++;
        if (out_data.cam_x !== exp_r.cam_x) begin
          $error("cam_x expected %0d actual %0d", exp_r.cam_x, out_data.cam_x);
          errors++;
        end
        if (out_data.cam_y !== exp_r.cam_y) begin
          $error("cam_y expected %0d actual %0d", exp_r.cam_y, out_data.cam_y);
          errors++;
        end
        if (out_data.cam_z !== exp_r.cam_z) begin
          $error("cam_z expected %0d actual %0d", exp_r.cam_z, out_data.cam_z);
          errors++;
        end
        if (out_data.out_intensity !== exp_r.out_intensity) begin
          $error("out_intensity expected %0d actual %0d",
                 exp_r.out_intensity, out_data.out_intensity);
          errors++;
        end
        if (out_data.pix_u !== exp_r.pix_u) begin
          $error("pix_u expected %0d actual %0d", exp_r.pix_u, out_data.pix_u);
          errors++;
        end
        if (out_data.pix_v !== exp_r.pix_v) begin
          $error("pix_v expected %0d actual %0d", exp_r.pix_v, out_data.pix_v);
          errors++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested. The
  // hold-off lets the internal queue fill so that the block stalls its input.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d predictions outstanding",
               cycles, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [REG_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    calib[idx] = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_calibration(logic [REG_W-1:0] v[NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) write_reg(reg_idx_e'(i), v[i]);
  endtask

  // Present one beat and hold it until accepted, then maybe idle for a while.
  task automatic send_beat(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    if (it.func == FUNC_POINT) points_sent++;
    else frames_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Sender pauses until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly points inside the camera frustum; some frame starts and raw noise.
  function automatic in_item_t random_beat();
    in_item_t it;
    logic [63:0] raw;
    int pick;
    pick = $urandom_range(99);
    raw = {$urandom, $urandom};
    it = '0;
    it.pt_intensity = 8'($urandom_range(255));
    if (pick == 0) begin
      it.func = FUNC_FRAME_START;
      it.pt_x = 16'($urandom);
      it.pt_y = 16'($urandom);
      it.pt_z = 16'($urandom);
    end else if (pick < 16) begin
      it = raw[$bits(in_item_t)-1:0];
      it.func = FUNC_POINT;
      it.pt_x = 16'($urandom);
    end else begin
      it.func = FUNC_POINT;
      it.pt_x = 16'($urandom_range(60 * 256, 4 * 256));
      it.pt_y = 16'(int'($urandom_range(30 * 256)) - 15 * 256);
      it.pt_z = 16'(int'($urandom_range(6 * 256)) - 3 * 256);
    end
    return it;
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_beat(random_beat());
  endtask

  function automatic in_item_t pt(int x, int y, int z, int inten);
    in_item_t it;
    it.func = FUNC_POINT;
    it.pt_x = x[15:0];
    it.pt_y = y[15:0];
    it.pt_z = z[15:0];
    it.pt_intensity = inten[7:0];
    return it;
  endfunction

  typedef struct {
    in_item_t beat;
    bit typed;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(in_item_t b, bit typed, out_item_t w);
    stim_row_t r;
    r.beat = b;
    r.typed = typed;
    r.want = w;
    directed = {directed, r};
  endtask

  initial begin
    logic [REG_W-1:0] camera[NUM_REGS];
    logic [REG_W-1:0] crowd[NUM_REGS];
    logic [REG_W-1:0] setting[NUM_REGS];
    out_item_t w;
    in_item_t fs;
    int first_cam_row;

    for (int i = 0; i < NUM_REGS; i++) calib[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With every register at zero a point lands at the origin, so behind camera.
    fs = '0;
    fs.func = FUNC_FRAME_START;
    fs.pt_x = 16'sh7FFF;
    fs.pt_intensity = 8'hFF;
    w = '0;
    w.status = ST_FRAME_CLEARED;
    add_row(fs, 1'b1, w);
    w.status = ST_BEHIND;
    w.out_intensity = 8'hFF;
    add_row(pt(32767, 32767, 32767, 255), 1'b1, w);
    w.out_intensity = 8'h00;
    add_row(pt(-32768, -32768, -32768, 0), 1'b1, w);
    w.out_intensity = 8'h5A;
    add_row(pt(0, 0, 0, 8'h5A), 1'b1, w);
    first_cam_row = directed.size();

    // Under the pinhole calibration the predictor decides these.
    add_row(pt(10 * 256, 0, 0, 1), 1'b0, w);        // image center
    add_row(pt(10 * 256, 0, 0, 2), 1'b0, w);        // taken, next row down
    add_row(pt(10 * 256, 0, 0, 3), 1'b0, w);
    add_row(pt(10 * 256, 20 * 256, 0, 4), 1'b0, w); // left part of image
    add_row(pt(10 * 256, -40 * 256, 0, 5), 1'b0, w);// off image to the right
    add_row(pt(-10 * 256, 0, 0, 6), 1'b0, w);       // behind camera
    add_row(pt(0, 0, 0, 7), 1'b0, w);               // depth exactly zero
    add_row(pt(32767, 0, 0, 8), 1'b0, w);           // too far
    add_row(pt(99 * 256, 0, 0, 9), 1'b0, w);        // just inside range
    add_row(pt(20 * 256, 0, 32767, 10), 1'b0, w);   // too far in z
    add_row(pt(20 * 256, 0, -32768, 11), 1'b0, w);
    add_row(pt(20 * 256, 32767, 0, 12), 1'b0, w);
    add_row(pt(20 * 256, -32768, 0, 13), 1'b0, w);
    add_row(fs, 1'b0, w);                           // clears the map
    add_row(pt(10 * 256, 0, 0, 14), 1'b0, w);       // center is free again
    add_row(pt(2 * 256, 0, -14 * 256, 15), 1'b0, w);// off the bottom edge

    // Reset-state rows: the typed expectations must agree with the predictor,
    // which in turn checks every result beat of the block.
    for (int i = 0; i < first_cam_row; i++) begin
      w = project_point(directed[i].beat);
      if (directed[i].typed && w !== directed[i].want) begin
        $error("directed row %0d: typed expectation disagrees with predictor", i);
        errors++;
      end
    end
    for (int i = 0; i < first_cam_row; i++) send_beat(directed[i].beat);
    drain_results();

    // Pinhole camera: lidar x forward maps to camera z, f = 200 px,
    // principal point (620, 187).
    camera[REG_ROT_ROW_X] = pack3(0, -16384, 0);
    camera[REG_ROT_ROW_Y] = pack3(0, 0, -16384);
    camera[REG_ROT_ROW_Z] = pack3(16384, 0, 0);
    camera[REG_SHIFT_XYZ] = pack3(0, 0, 0);
    camera[REG_PROJ_ROW_U] = pack3(200 * 16, 0, 620 * 16);
    camera[REG_PROJ_ROW_V] = pack3(0, 200 * 16, 187 * 16);
    camera[REG_PROJ_ROW_W] = pack3(0, 0, 16384);
    camera[REG_PROJ_OFFSET] = pack3(0, 0, 0);
    load_calibration(camera);
    for (int i = first_cam_row; i < directed.size(); i++) send_beat(directed[i].beat);
    drain_results();

    // Four idling patterns over mostly well-formed point streams.
    send_idle_pct = 0;  recv_stall_pct = 0;  random_run(300);
    send_idle_pct = 75; recv_stall_pct = 0;  random_run(280);
    send_idle_pct = 0;  recv_stall_pct = 75; random_run(280);
    send_idle_pct = 24; recv_stall_pct = 24; random_run(150);
    // Long receiver hold-off while points keep coming.
    send_idle_pct = 0;
    hold_cycles = 3000;
    random_run(150);
    drain_results();

    // Everything projects near the bottom of one column, so the column fills.
    crowd = camera;
    crowd[REG_SHIFT_XYZ] = pack3(0, 0, 2048);
    crowd[REG_PROJ_ROW_U] = pack3(0, 0, 620 * 16);
    crowd[REG_PROJ_ROW_V] = pack3(0, 0, 370 * 16);
    load_calibration(crowd);
    recv_stall_pct = 24;
    random_run(60);
    drain_results();

    // Extremes and a random calibration; saturation and nonpositive depth.
    for (int i = 0; i < NUM_REGS; i++) setting[i] = pack3(32767, 32767, 32767);
    load_calibration(setting);
    random_run(60);
    drain_results();
    for (int i = 0; i < NUM_REGS; i++) setting[i] = pack3(-32768, -32768, -32768);
    load_calibration(setting);
    random_run(60);
    drain_results();
    for (int i = 0; i < NUM_REGS; i++) setting[i] = REG_W'({$urandom, $urandom});
    setting[REG_ROT_ROW_Z] = pack3(16384, 0, 0);
    setting[REG_PROJ_ROW_W] = pack3(int'($urandom_range(8192)) - 4096, 0, 16384);
    load_calibration(setting);
    random_run(60);
    drain_results();

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d points and %0d frame starts over six calibrations;",
             points_sent, frames_sent);
    $display("%0d results checked, %0d placed, %0d column full", results_seen,
             placed_seen, full_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
